// ===== design/pair_key_lookup_allocate_macros.svh =====
// ----------------------------------------------------------------------------
// pair key lookup allocate assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef PAIR_KEY_LOOKUP_ALLOCATE_MACROS_SVH
`define PAIR_KEY_LOOKUP_ALLOCATE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PKLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PKLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pkla_pkg.sv =====
// ----------------------------------------------------------------------------
// pkla_pkg
// shared types and constants of the pair key lookup allocate block
// ----------------------------------------------------------------------------
package pkla_pkg;

  localparam int ADDR_W        = 48;
  localparam int APP_ID_W      = 16;
  localparam int KEY_LEN_W     = 8;
  localparam int IDX_OUT_W     = 4;
  localparam int NODES_DEFAULT = 16;

  localparam logic [APP_ID_W-1:0]  APP_ID  = 16'h8070;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN = 8'd14;

  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_BAD_KEY   = 2'd1,
    RC_SAME_PAIR = 2'd2,
    RC_FULL      = 2'd3
  } reject_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ROW,
    ST_ROW_WAIT,
    ST_COL,
    ST_COL_WAIT,
    ST_OUT
  } top_state_t;

  typedef enum logic {
    SC_IDLE,
    SC_SCAN
  } scan_state_t;

  typedef struct packed {
    logic done;
    logic ok;
  } scan_rsp_t;

endpackage

// ===== design/pkla_scan.sv =====
// ----------------------------------------------------------------------------
// pkla_scan
// address table with one comparator: linear lookup, allocate on miss
// ----------------------------------------------------------------------------
module pkla_scan
  import pkla_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ADDR_W-1:0]              key,
  output scan_rsp_t                      rsp,
  output logic [$clog2(NODES)-1:0]       slot
);

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NODES);

  scan_state_t       state;
  scan_state_t       state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  cmp_idx;
  logic              pend;
  logic [ADDR_W-1:0] mem [NODES];
  logic [ADDR_W-1:0] rdata;

  logic hit;
  logic more;
  logic miss;
  logic room;
  logic rd_en;
  logic wr_en;

  // entries below count are the filled ones
  assign hit  = pend && (rdata == key);
  assign more = rd_idx < count;
  assign miss = !pend && !more;
  assign room = count < FULL_CNT;

  always_comb begin
    state_next = state;
    case (state)
      SC_IDLE: if (start) state_next = SC_SCAN;
      SC_SCAN: if (hit || miss) state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = 1'b0;
    rsp.ok   = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    slot     = hit ? cmp_idx : count[IDX_W-1:0];
    case (state)
      SC_IDLE: begin
        rsp.done = 1'b0;
      end
      SC_SCAN: begin
        rsp.done = hit || miss;
        rsp.ok   = hit || room;
        rd_en    = more && !hit;
        wr_en    = miss && room;
      end
      default: begin
        rsp.done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SC_IDLE;
      count  <= '0;
      rd_idx <= '0;
      pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == SC_IDLE) begin
        rd_idx <= '0;
        pend   <= 1'b0;
      end else begin
        pend <= rd_en;
        if (rd_en) rd_idx <= rd_idx + CNT_W'(1);
      end
      if (wr_en) count <= count + CNT_W'(1);
    end
  end

  // one read port feeding the comparator, one write port for allocation
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata   <= mem[rd_idx[IDX_W-1:0]];
      cmp_idx <= rd_idx[IDX_W-1:0];
    end
    if (wr_en) mem[count[IDX_W-1:0]] <= key;
  end

endmodule

// ===== design/pair_key_lookup_allocate.sv =====
// a bad id/length or same-device request goes from the check straight to the
//   result; otherwise the row and then the col address are looked up in turn
// one request at a time; a new beat can be taken in the cycle after the result
//   beat is taken, and lookup time is set by the single table read port and
//   its comparator walking the filled entries
// reset: rst (synchronous) empties the table, clears own_address and idles
// ----------------------------------------------------------------------------
// pair_key_lookup_allocate
// checks a key request, then, unless rejected, looks up or allocates both device addresses
// ----------------------------------------------------------------------------
module pair_key_lookup_allocate
  import pkla_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [APP_ID_W-1:0]  app_id,
  input  logic [KEY_LEN_W-1:0] key_length,
  input  logic [ADDR_W-1:0]    first_address,
  input  logic [ADDR_W-1:0]    second_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 accepted,
  output logic [1:0]           reject_code,
  output logic [IDX_OUT_W-1:0] row_index,
  output logic [IDX_OUT_W-1:0] col_index
);

  localparam int IDX_W = $clog2(NODES);

  top_state_t           state;
  top_state_t           state_next;
  logic [ADDR_W-1:0]    own_address;
  logic [APP_ID_W-1:0]  id_q;
  logic [KEY_LEN_W-1:0] len_q;
  logic [ADDR_W-1:0]    addr_a;
  logic [ADDR_W-1:0]    addr_b;
  logic [IDX_W-1:0]     row_slot;
  logic                 row_ok;

  logic                 scan_start;
  logic [ADDR_W-1:0]    scan_key;
  scan_rsp_t            scan_rsp;
  logic [IDX_W-1:0]     scan_slot;

  logic                 bad_key;
  logic                 same_pair;
  logic [IDX_W+IDX_OUT_W-1:0] row_wide;
  logic [IDX_W+IDX_OUT_W-1:0] col_wide;

  assign bad_key   = (id_q != APP_ID) || (len_q != KEY_LEN);
  assign same_pair = (addr_a == addr_b) && (addr_a != own_address);
  assign scan_key  = ((state == ST_COL) || (state == ST_COL_WAIT)) ? addr_b : addr_a;
  // report only the low index bits
  assign row_wide  = {{IDX_OUT_W{1'b0}}, row_slot};
  assign col_wide  = {{IDX_OUT_W{1'b0}}, scan_slot};

  pkla_scan #(
    .NODES (NODES)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .key   (scan_key),
    .rsp   (scan_rsp),
    .slot  (scan_slot)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_CHECK;
      ST_CHECK:    state_next = (bad_key || same_pair) ? ST_OUT : ST_ROW;
      ST_ROW:      state_next = ST_ROW_WAIT;
      ST_ROW_WAIT: if (scan_rsp.done) state_next = ST_COL;
      ST_COL:      state_next = ST_COL_WAIT;
      ST_COL_WAIT: if (scan_rsp.done) state_next = ST_OUT;
      ST_OUT:      if (out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    scan_start = 1'b0;
    case (state)
      ST_IDLE:  in_ready   = !rst;
      ST_ROW:   scan_start = 1'b1;
      ST_COL:   scan_start = 1'b1;
      ST_OUT:   out_valid  = 1'b1;
      default:  in_ready   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      own_address <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) own_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      id_q   <= app_id;
      len_q  <= key_length;
      addr_a <= first_address;
      addr_b <= second_address;
    end
    if (state == ST_CHECK) begin
      accepted    <= 1'b0;
      row_index   <= '0;
      col_index   <= '0;
      reject_code <= bad_key ? RC_BAD_KEY : RC_SAME_PAIR;
    end
    if ((state == ST_ROW_WAIT) && scan_rsp.done) begin
      row_slot <= scan_slot;
      row_ok   <= scan_rsp.ok;
    end
    if ((state == ST_COL_WAIT) && scan_rsp.done) begin
      if (row_ok && scan_rsp.ok) begin
        accepted    <= 1'b1;
        reject_code <= RC_OK;
        row_index   <= row_wide[IDX_OUT_W-1:0];
        col_index   <= col_wide[IDX_OUT_W-1:0];
      end else begin
        accepted    <= 1'b0;
        reject_code <= RC_FULL;
        row_index   <= '0;
        col_index   <= '0;
      end
    end
  end

endmodule

// ===== design/pkla_checker.sv =====
// ----------------------------------------------------------------------------
// pkla_checker
// port-level checks of the pair key lookup allocate block
// ----------------------------------------------------------------------------
`include "pair_key_lookup_allocate_macros.svh"

module pkla_checker
  import pkla_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 accepted,
  input logic [1:0]           reject_code,
  input logic [IDX_OUT_W-1:0] row_index,
  input logic [IDX_OUT_W-1:0] col_index
);

  // one request in flight: no new beat while a result waits
  `PKLA_ASSERT_NOW(a_one_in_flight, in_ready, !out_valid, "input taken while result pending")

  // an accepted input is never answered in the same or next cycle
  `PKLA_ASSERT_NEXT(a_in_then_busy, in_valid && in_ready, !out_valid && !in_ready, "result too early")

  // accepted results carry an ok code, rejects carry zero indices
  `PKLA_ASSERT_NOW(a_accept_code, out_valid && accepted, reject_code == RC_OK, "accepted with reject code")
  `PKLA_ASSERT_NOW(a_reject_idx, out_valid && !accepted, reject_code != RC_OK && row_index == '0 && col_index == '0, "reject beat malformed")

  // a stalled result beat holds
  `PKLA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(accepted) && $stable(reject_code) && $stable(row_index) && $stable(col_index), "result changed under stall")

endmodule

bind pair_key_lookup_allocate pkla_checker u_pkla_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .accepted    (accepted),
  .reject_code (reject_code),
  .row_index   (row_index),
  .col_index   (col_index)
);
